// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character map for the base64 stream encoder.
package b64e_pkg;

   // Word widths
   localparam int ByteW = 8;
   localparam int SixW  = 6;

   // Queue between the front and back parts
   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);
   localparam int QCw    = $clog2(QDepth + 1);

   // Position within the 3-byte group
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } b64e_phase_type;

   // One queued unit of work: one or two characters from one byte
   typedef struct packed {
      logic [SixW-1:0] six0;
      logic [SixW-1:0] six1;
      logic            two;   // second character present
      logic            eot;   // second character ends the message
   } b64e_entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } b64e_qstat_type;

   // Map a 6-bit value onto the standard alphabet
   function automatic logic [ByteW-1:0] b64_char(input logic [SixW-1:0] six);
      logic [ByteW-1:0] wide;
      logic [ByteW-1:0] res;
      wide = {2'b00, six};
      if (six < 6'd26) begin
         res = 8'h41 + wide;
      end else if (six < 6'd52) begin
         res = 8'h61 + wide - 8'd26;
      end else if (six < 6'd62) begin
         res = 8'h30 + wide - 8'd52;
      end else if (six == 6'd62) begin
         res = 8'h2B;
      end else begin
         res = 8'h2F;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
// Valid/ready channel interfaces for raw bytes in and base64 characters out.
interface b64e_req_if import b64e_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_rsp_if import b64e_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] code_char;
   logic             end_of_text;

   modport source (output valid, output code_char, output end_of_text, input ready);
   modport sink   (input valid, input code_char, input end_of_text, output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// Front part: accepts raw bytes, tracks group position and splits bytes into 6-bit codes.
module b64e_front import b64e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   b64e_req_if.sink       req_ch,
   input  b64e_qstat_type q_stat,
   output logic           push,
   output b64e_entry_type entry
);

   b64e_phase_type   phase_ff, phase_in;
   logic [3:0]       left_ff, left_in;
   logic [ByteW-1:0] b;
   logic             last;

   assign b            = req_ch.data_byte;
   assign last         = req_ch.last_byte;
   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full;

   // Split the byte by group position
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      case (phase_ff)
         PH_SECOND: begin
            entry.six0 = {left_ff[1:0], b[7:4]};
            entry.six1 = {b[3:0], 2'b00};
            entry.two  = last;
            entry.eot  = last;
            phase_in   = PH_THIRD;
            left_in    = b[3:0];
         end
         PH_THIRD: begin
            entry.six0 = {left_ff[3:0], b[7:6]};
            entry.six1 = b[5:0];
            entry.two  = 1'b1;
            entry.eot  = last;
            phase_in   = PH_FIRST;
            left_in    = 4'd0;
         end
         default: begin
            // start of group; unused code behaves the same
            entry.six0 = b[7:2];
            entry.six1 = {b[1:0], 4'b0000};
            entry.two  = last;
            entry.eot  = last;
            phase_in   = PH_SECOND;
            left_in    = {2'b00, b[1:0]};
         end
      endcase
      // end of message restarts the group
      if (last) begin
         phase_in = PH_FIRST;
         left_in  = 4'd0;
      end
   end

   // Group state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Short queue of work entries between the front and back parts.
module b64e_queue import b64e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64e_entry_type push_entry,
   input  logic           pop,
   output b64e_entry_type head,
   output b64e_qstat_type q_stat
);

   b64e_entry_type   mem [QDepth];
   logic [QAw-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCw-1:0]   count_ff, count_in;

   assign head         = mem[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCw'(QDepth));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCw'(QDepth)) else $error("queue fill level out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("fill level did not follow push");
`endif

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back part: queued codes to base64 chars, one per cycle unless stalled.
module b64e_back import b64e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  b64e_entry_type head,
   input  b64e_qstat_type q_stat,
   output logic           pop,
   b64e_rsp_if.source     rsp_ch
);

   logic             out_valid_ff, out_valid_in;
   logic [ByteW-1:0] out_char_ff, out_char_in;
   logic             out_eot_ff, out_eot_in;
   logic             pos_ff, pos_in;
   logic             load;

   assign load = !out_valid_ff || rsp_ch.ready;

   // Pick the next character from the head entry
   always_comb begin
      pop          = 1'b0;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_eot_in   = out_eot_ff;
      if (load) begin
         out_valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            out_char_in = b64_char(pos_ff ? head.six1 : head.six0);
            out_eot_in  = pos_ff && head.eot;
            if (pos_ff || !head.two) begin
               pop    = 1'b1;
               pos_in = 1'b0;
            end else begin
               pos_in = 1'b1;
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pos_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
      out_char_ff <= out_char_in;
      out_eot_ff  <= out_eot_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.code_char   = out_char_ff;
   assign rsp_ch.end_of_text = out_eot_ff;

`ifndef SYNTHESIS
   a_second_needs_head: assert property (@(posedge clock) disable iff (reset)
      pos_ff |-> !q_stat.empty) else $error("second character without entry");
   a_eot_on_second: assert property (@(posedge clock) disable iff (reset)
      (load && !q_stat.empty && !pos_ff) |=> !out_eot_ff)
      else $error("end flag on first character of entry");
   a_pos_clear_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> !pos_ff) else $error("position not cleared after pop");
`endif

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Top level of the unpadded base64 stream encoder.
//
// Usage: raw message bytes enter on req_ch (data_byte, last_byte set on the
// final byte of a message); base64 characters leave on rsp_ch (code_char,
// end_of_text set on the final character). Both are valid/ready channels;
// a word moves at a clock edge with valid and ready high.
// Each byte yields one character, or two at the third byte of a group and
// on the last byte of a message that ends inside a group. No padding.
// An accepted byte is first written into the queue; its characters then pass
// through the output register, which gives one character per cycle while the
// receiver is ready and the queue holds an entry.
// A four-entry queue between the byte splitter and the character stage lets
// the input keep accepting while the receiver stalls, until the queue fills;
// then req_ch.ready drops. Output words hold steady while stalled.
// Reset (synchronous, active high) empties the queue and output register and
// starts a fresh group; no clearing pass is needed.
module base64_stream_encoder import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_ch,
   b64e_rsp_if.source rsp_ch
);

   logic           push;
   logic           pop;
   b64e_entry_type push_entry;
   b64e_entry_type head;
   b64e_qstat_type q_stat;

   b64e_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_stat (q_stat),
      .push   (push),
      .entry  (push_entry)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   b64e_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
